[hdl/tklsk_pkg.sv]
// -----------------------------------------------------------------------------
// Top-K lowest score keeper package
// Shared sizes, codes and structs for the keeper's front queue, sorted chain
// and back engine.
// -----------------------------------------------------------------------------
`default_nettype none

package tklsk_pkg;

   // Number of ranked entries held (1 to 64)
   localparam int KEEP        = 64;
   localparam int SCORE_W     = 32;
   localparam int SLOT_W      = 6;
   localparam int CNT_W       = $clog2(KEEP + 1);

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_OFFER = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [SCORE_W-1:0]  score;
   } item_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } chain_cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic              full;
      logic              reject;
      logic [SLOT_W-1:0] new_slot;
      logic [SLOT_W-1:0] head_slot;
   } chain_stat_type;

   typedef enum logic {
      BK_IDLE  = 1'b0,
      BK_DRAIN = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

[hdl/tklsk_front.sv]
// -----------------------------------------------------------------------------
// Top-K keeper front end
// Accepts request transactions, decodes the opcode and queues them for the
// back engine.
// -----------------------------------------------------------------------------
`default_nettype none

module tklsk_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_opcode,
   input  wire logic signed [tklsk_pkg::SCORE_W-1:0]    req_score,
   output logic                                         q_valid,
   output tklsk_pkg::item_type                          q_item,
   input  wire logic                                    q_pop
);

   tklsk_pkg::item_type               queue_ff [tklsk_pkg::QUEUE_DEPTH];
   logic [tklsk_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tklsk_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tklsk_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;
   logic                              push;
   logic                              pop;
   tklsk_pkg::item_type               new_item;

   // classify the incoming transaction
   always_comb begin
      new_item.op    = req_opcode ? tklsk_pkg::OP_DRAIN : tklsk_pkg::OP_OFFER;
      new_item.score = req_score;
   end

   assign req_stall = (cnt_ff == tklsk_pkg::QCNT_W'(tklsk_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tklsk_pkg::QPTR_W'(tklsk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tklsk_pkg::QPTR_W'(tklsk_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= tklsk_pkg::QCNT_W'(tklsk_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

`default_nettype wire

[hdl/tklsk_chain.sv]
// -----------------------------------------------------------------------------
// Top-K keeper sorted chain
// Row of cells holding score and slot in rank order; inserts with a local
// shift and pops the head for drains.
// -----------------------------------------------------------------------------
`default_nettype none

module tklsk_chain (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  tklsk_pkg::chain_cmd_type                     cmd,
   input  wire logic signed [tklsk_pkg::SCORE_W-1:0]    key,
   output tklsk_pkg::chain_stat_type                    stat
);

   localparam int K = tklsk_pkg::KEEP;

   logic signed [tklsk_pkg::SCORE_W-1:0] score_ff [K];
   logic signed [tklsk_pkg::SCORE_W-1:0] score_in [K];
   logic [tklsk_pkg::SLOT_W-1:0]         slot_ff  [K];
   logic [tklsk_pkg::SLOT_W-1:0]         slot_in  [K];
   logic signed [tklsk_pkg::SCORE_W-1:0] prev_score [K];
   logic [tklsk_pkg::SLOT_W-1:0]         prev_slot  [K];
   logic signed [tklsk_pkg::SCORE_W-1:0] next_score [K];
   logic [tklsk_pkg::SLOT_W-1:0]         next_slot  [K];
   logic [K-1:0]                         le;
   logic [K-1:0]                         prev_le;
   logic [tklsk_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                                 full;
   logic                                 reject;
   logic                                 do_insert;
   logic [tklsk_pkg::SLOT_W-1:0]         new_slot;

   assign full      = (count_ff == tklsk_pkg::CNT_W'(K));
   assign reject    = full && le[K-1];
   assign do_insert = cmd.insert && !reject;
   assign new_slot  = full ? slot_ff[K-1] : tklsk_pkg::SLOT_W'(count_ff);

   for (genvar i = 0; i < K; i++) begin : g_cell
      // held entry ranks at or before the new key
      assign le[i] = (tklsk_pkg::CNT_W'(i) < count_ff) && (score_ff[i] <= key);

      if (i == 0) begin : g_head
         assign prev_le[i]    = 1'b1;
         assign prev_score[i] = score_ff[i];
         assign prev_slot[i]  = slot_ff[i];
      end else begin : g_body
         assign prev_le[i]    = le[i-1];
         assign prev_score[i] = score_ff[i-1];
         assign prev_slot[i]  = slot_ff[i-1];
      end

      if (i == K - 1) begin : g_tail
         assign next_score[i] = score_ff[i];
         assign next_slot[i]  = slot_ff[i];
      end else begin : g_mid
         assign next_score[i] = score_ff[i+1];
         assign next_slot[i]  = slot_ff[i+1];
      end

      always_comb begin
         score_in[i] = score_ff[i];
         slot_in[i]  = slot_ff[i];
         if (do_insert && !le[i]) begin
            if (prev_le[i]) begin
               score_in[i] = key;
               slot_in[i]  = new_slot;
            end else begin
               score_in[i] = prev_score[i];
               slot_in[i]  = prev_slot[i];
            end
         end else if (cmd.pop) begin
            score_in[i] = next_score[i];
            slot_in[i]  = next_slot[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert && !full) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < K; j++) begin
         score_ff[j] <= score_in[j];
         slot_ff[j]  <= slot_in[j];
      end
   end

   always_comb begin
      stat.count     = count_ff;
      stat.full      = full;
      stat.reject    = reject;
      stat.new_slot  = new_slot;
      stat.head_slot = slot_ff[0];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tklsk_pkg::CNT_W'(K))
      else $error("held count above capacity");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.insert && cmd.pop))
      else $error("insert and pop in the same cycle");

endmodule

`default_nettype wire

[hdl/tklsk_back.sv]
// -----------------------------------------------------------------------------
// Top-K keeper back engine
// Executes queued offers and drains against the sorted chain and holds the
// response transaction in an output register.
// -----------------------------------------------------------------------------
`default_nettype none

module tklsk_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              q_valid,
   input  tklsk_pkg::item_type                    q_item,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_entry_valid,
   output logic [tklsk_pkg::SLOT_W-1:0]           rsp_slot,
   output logic                                   rsp_last
);

   tklsk_pkg::back_state_type    state_ff, state_in;
   tklsk_pkg::chain_cmd_type     cmd;
   tklsk_pkg::chain_stat_type    stat;
   logic                         out_free;
   logic                         load;
   logic                         load_entry_valid;
   logic [tklsk_pkg::SLOT_W-1:0] load_slot;
   logic                         load_last;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_entry_valid_ff;
   logic [tklsk_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic                         rsp_last_ff;

   tklsk_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .key   (q_item.score),
      .stat  (stat)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tklsk_pkg::BK_IDLE: begin
            if (q_valid && out_free && (q_item.op == tklsk_pkg::OP_DRAIN) &&
                (stat.count != '0)) begin
               state_in = tklsk_pkg::BK_DRAIN;
            end
         end
         tklsk_pkg::BK_DRAIN: begin
            if (out_free && (stat.count == tklsk_pkg::CNT_W'(1))) begin
               state_in = tklsk_pkg::BK_IDLE;
            end
         end
         default: state_in = tklsk_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop            = 1'b0;
      cmd.insert       = 1'b0;
      cmd.pop          = 1'b0;
      load             = 1'b0;
      load_entry_valid = 1'b0;
      load_slot        = '0;
      load_last        = 1'b1;
      case (state_ff)
         tklsk_pkg::BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (q_item.op == tklsk_pkg::OP_OFFER) begin
                  cmd.insert       = 1'b1;
                  load             = 1'b1;
                  load_entry_valid = !stat.reject;
                  load_slot        = stat.reject ? '0 : stat.new_slot;
               end else if (stat.count == '0) begin
                  // empty drain: one invalid result
                  load = 1'b1;
               end
            end
         end
         tklsk_pkg::BK_DRAIN: begin
            if (out_free) begin
               cmd.pop          = 1'b1;
               load             = 1'b1;
               load_entry_valid = 1'b1;
               load_slot        = stat.head_slot;
               load_last        = (stat.count == tklsk_pkg::CNT_W'(1));
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tklsk_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_entry_valid_ff <= load_entry_valid;
         rsp_slot_ff        <= load_slot;
         rsp_last_ff        <= load_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_valid = rsp_entry_valid_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_last        = rsp_last_ff;

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tklsk_pkg::BK_DRAIN) |-> (stat.count != '0))
      else $error("drain state with an empty chain");

   a_offer_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.insert && !stat.reject && !stat.full) |=>
         (stat.count == $past(stat.count) + 1'b1))
      else $error("accepted offer did not grow the held count");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop || cmd.insert) |-> load)
      else $error("chain update without a response");

endmodule

`default_nettype wire

[hdl/top_k_lowest_score_keeper_core.sv]
// -----------------------------------------------------------------------------
// Top-K lowest score keeper core
// Keeps the KEEP lowest signed Q16.16 scores offered, ranked best to worst,
// reports the record slot for each accepted offer and lists ranked slots on
// a drain.
// -----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_*     in         req_valid/req_stall  req_opcode, req_score
//   rsp_*     out        rsp_valid/rsp_stall  rsp_entry_valid, rsp_slot, rsp_last
//
// Flow: for an offer all chain cells compare the score in parallel and shift
//   in the same cycle; a drain first enters the drain state, then gives one
//   result per ranked slot, and an empty drain gives a single invalid result.
//   The back engine's output register takes one result per cycle unless
//   rsp_stall holds it; the two-entry queue registers each transaction.
// Reset: synchronous; clears the queue, the held count and the response
//   valid. Cell contents are not cleared; the held count marks which are live.
// Stalls: rsp_stall holds the response register and the back engine; the
//   queue keeps taking transactions until it holds two, then raises req_stall.
// -----------------------------------------------------------------------------
`default_nettype none

module top_k_lowest_score_keeper_core (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_stall,
   input  wire logic                                    req_opcode,
   input  wire logic signed [tklsk_pkg::SCORE_W-1:0]    req_score,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic                                         rsp_entry_valid,
   output logic [tklsk_pkg::SLOT_W-1:0]                 rsp_slot,
   output logic                                         rsp_last
);

   logic                 q_valid;
   logic                 q_pop;
   tklsk_pkg::item_type  q_item;

   // Front: accept and decode transactions, queue them
   tklsk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_score  (req_score),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back: run offers and drains on the sorted chain, drive responses
   tklsk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_slot        (rsp_slot),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
